/* rtl/core/ring_log_slot_allocator_macros.svh */
// Assertion macros used by the slot allocator controller.
`ifndef RING_LOG_SLOT_ALLOCATOR_MACROS_SVH
`define RING_LOG_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define RLSA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rlsa: same-cycle check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define RLSA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rlsa: next-cycle check failed");

`endif

/* rtl/core/rlsa_pkg.sv */
// Package with the shared types and constants of the log slot allocator.
package rlsa_pkg;

    localparam int BUFFER_BYTES_DEF = 16384;
    localparam int MAX_REQUEST_DEF  = 1024;
    localparam int HDR_BYTES        = 8;

    localparam logic [1:0] PRIO_FREE         = 2'd3;
    localparam logic [7:0] SPLIT_SLACK_RESET = 8'd20;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [0:0] REG_SPLIT_SLACK = 1'b0;

    typedef struct packed {
        logic [1:0]  priority_req;
        logic [10:0] request_bytes;
    } in_item_t;

    typedef struct packed {
        logic [13:0] message_offset;
        logic [13:0] reserved_bytes;
        logic        wrapped;
    } out_item_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic load;
        logic step;
        logic wrap;
        logic absorb;
        logic commit;
        logic split;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic fits;
        logic at_end;
    } dp_sts_t;

endpackage

/* rtl/core/rlsa_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module rlsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rlsa_dp.sv */
// Datapath of the log slot allocator: header store, walk registers and result register.
module rlsa_dp #(
    parameter int BUFFER_BYTES = rlsa_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_REQUEST  = rlsa_pkg::MAX_REQUEST_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rlsa_pkg::dp_cmd_t   cmd,
    input  logic [7:0]          split_slack,
    input  rlsa_pkg::in_item_t  in_item,
    output rlsa_pkg::dp_sts_t   sts,
    output rlsa_pkg::out_item_t out_item
);

    localparam int SLOTS = BUFFER_BYTES / 4;
    localparam int IW    = $clog2(SLOTS);
    localparam int SW    = $clog2(BUFFER_BYTES);
    localparam int OW    = SW + 1;
    localparam int EW    = SW + 2;
    localparam int CW    = (OW > 13) ? OW : 13;

    localparam logic [CW-1:0] CAP_C  = CW'((BUFFER_BYTES - rlsa_pkg::HDR_BYTES) & ~3);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_REQUEST);
    localparam logic [OW-1:0] HDR_C  = OW'(rlsa_pkg::HDR_BYTES);
    localparam logic [OW-1:0] BUF_C  = OW'(BUFFER_BYTES);
    localparam logic [SW-1:0] INIT_C = SW'(BUFFER_BYTES - rlsa_pkg::HDR_BYTES);

    logic [OW-1:0]       top_offset_reg;
    logic [OW-1:0]       top_reg;
    logic [OW-1:0]       size_reg;
    logic [OW-1:0]       free_reg;
    logic [OW-1:0]       next_reg;
    logic [OW-1:0]       rem_reg;
    logic [1:0]          prio_reg;
    logic                wrapped_reg;
    logic                split_reg;
    logic [IW-1:0]       clr_cnt_reg;
    rlsa_pkg::out_item_t out_reg;

    logic [CW-1:0] req_c;
    logic [CW-1:0] rnd_c;
    logic [OW-1:0] size_in;
    logic [OW-1:0] rd_size;
    logic [OW-1:0] absorbed;
    logic [OW-1:0] rem_all;
    logic          split_now;
    logic [OW-1:0] res_bytes;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    always_comb begin
        req_c = CW'(in_item.request_bytes);
        if (req_c == '0) begin
            req_c = CW'(1);
        end
        if (req_c > MAX_C) begin
            req_c = MAX_C;
        end
        rnd_c = (req_c + CW'(3)) & ~CW'(3);
        if (rnd_c > CAP_C) begin
            rnd_c = CAP_C;
        end
        size_in = OW'(rnd_c);
    end

    assign rd_size   = OW'(rd_data[SW-1:0]);
    assign absorbed  = HDR_C + rd_size;
    assign rem_all   = free_reg - size_reg;
    assign split_now = rem_all > (HDR_C + OW'(split_slack));
    assign res_bytes = split_now ? size_reg : free_reg;

    assign sts.clr_last = (clr_cnt_reg == IW'(SLOTS - 1));
    assign sts.fits     = (free_reg >= size_reg);
    assign sts.at_end   = (next_reg >= BUF_C);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = top_reg[IW+1:2];
        wr_data = {rlsa_pkg::PRIO_FREE, free_reg[SW-1:0]};
        if (cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = (clr_cnt_reg == '0) ? {rlsa_pkg::PRIO_FREE, INIT_C} : '0;
        end else if (cmd.wrap) begin
            wr_en = 1'b1;
        end else if (cmd.commit) begin
            wr_en   = 1'b1;
            wr_data = {prio_reg, res_bytes[SW-1:0]};
        end else if (cmd.split && split_reg) begin
            wr_en   = 1'b1;
            wr_data = {rlsa_pkg::PRIO_FREE, rem_reg[SW-1:0]};
        end
    end

    always_comb begin
        rd_addr = '0;
        if (cmd.accept) begin
            rd_addr = top_offset_reg[IW+1:2];
        end else if (cmd.step) begin
            rd_addr = next_reg[IW+1:2];
        end
    end

    rlsa_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_offset_reg <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.accept) begin
                top_reg     <= top_offset_reg;
                size_reg    <= size_in;
                prio_reg    <= in_item.priority_req;
                wrapped_reg <= 1'b0;
            end
            if (cmd.load) begin
                free_reg <= rd_size;
                next_reg <= top_reg + HDR_C + rd_size;
            end
            if (cmd.absorb) begin
                free_reg <= free_reg + absorbed;
                next_reg <= next_reg + absorbed;
            end
            if (cmd.wrap) begin
                top_reg     <= '0;
                wrapped_reg <= 1'b1;
            end
            if (cmd.commit) begin
                top_reg                <= top_reg + HDR_C + res_bytes;
                split_reg              <= split_now;
                rem_reg                <= rem_all - HDR_C;
                out_reg.message_offset <= 14'(top_reg + HDR_C);
                out_reg.reserved_bytes <= 14'(res_bytes);
                out_reg.wrapped        <= wrapped_reg;
            end
            if (cmd.split) begin
                top_offset_reg <= (top_reg >= BUF_C) ? '0 : top_reg;
            end
        end
    end

    assign out_item = out_reg;

endmodule

/* rtl/core/rlsa_ctrl.sv */
// Controller state machine of the log slot allocator.
`include "ring_log_slot_allocator_macros.svh"

module rlsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rlsa_pkg::dp_sts_t sts,
    output rlsa_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_ABSORB,
        S_COMMIT,
        S_SPLIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.fits) begin
                    state_next = S_COMMIT;
                end else if (sts.at_end) begin
                    cmd.wrap   = 1'b1;
                    state_next = S_LOAD;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_ABSORB;
                end
            end
            S_ABSORB: begin
                cmd.absorb = 1'b1;
                state_next = S_CHECK;
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_SPLIT;
                end
            end
            S_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `RLSA_ASSERT_NXT(a_accept_starts_walk, aclk, aresetn, in_valid && in_ready, state_reg == S_LOAD)
    `RLSA_ASSERT_IMP(a_commit_into_free_slot, aclk, aresetn, cmd.commit, out_free)
    `RLSA_ASSERT_IMP(a_result_from_commit, aclk, aresetn, $rose(out_valid_reg), $past(state_reg == S_COMMIT))

endmodule

/* rtl/core/ring_log_slot_allocator.sv */
// Top level of the log slot allocator: item channels, register port and submodules.
//
// Allocates variable-length log records in a ring of slot headers. An item on the
// s_ channel gives a priority and a byte length; the m_ channel returns one item
// with the data offset, the reserved size and a flag set when the walk wrapped.
// The split_slack register sits at byte address 0 of the APB port.
// After reset the header store is cleared, all BUFFER_BYTES/4 slot headers
// (4096 by default); s_ready stays low until it is done.
// The block works on one item at a time and takes no new item until the last
// one has been committed and split. Each slot header read beyond the first
// (absorbed slots plus wrap restarts) is one read of the single header RAM
// port and one add. A result waits in an output register; a stalled receiver
// holds it, and the block keeps taking and walking the next item but does not
// finish it until the waiting result has been taken.
module ring_log_slot_allocator #(
    parameter int BUFFER_BYTES = rlsa_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_REQUEST  = rlsa_pkg::MAX_REQUEST_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rlsa_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rlsa_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlsa_pkg::APB_AW-1:0]   paddr,
    input  logic [rlsa_pkg::APB_DW-1:0]   pwdata,
    output logic [rlsa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    rlsa_pkg::dp_cmd_t cmd;
    rlsa_pkg::dp_sts_t sts;
    logic [7:0]        split_slack_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_slack_reg <= rlsa_pkg::SPLIT_SLACK_RESET;
        end else if (cfg_wr && (paddr[2:2] == rlsa_pkg::REG_SPLIT_SLACK)) begin
            split_slack_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[2:2])
            rlsa_pkg::REG_SPLIT_SLACK: prdata = {24'd0, split_slack_reg};
            default:                   prdata = '0;
        endcase
    end

    rlsa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlsa_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_REQUEST  (MAX_REQUEST)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .split_slack (split_slack_reg),
        .in_item     (s_data),
        .sts         (sts),
        .out_item    (m_data)
    );

endmodule
